// ===== rtl/stsc_pkg.sv =====
`timescale 1ns / 1ps
// stsc_pkg: shared types and constants of the script token scanner
// no dependencies; used by every module under rtl

package stsc_pkg;

    localparam int LINE_BITS_DEFAULT = 16;
    localparam int LINE_OUT_BITS     = 16;

    // scan modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_STR  = 2'd1;
    localparam logic [1:0] MODE_INT  = 2'd2;
    localparam logic [1:0] MODE_ID   = 2'd3;

    // token kinds
    localparam logic [3:0] KIND_STR   = 4'd0;
    localparam logic [3:0] KIND_INT   = 4'd1;
    localparam logic [3:0] KIND_ID    = 4'd2;
    localparam logic [3:0] KIND_SEMI  = 4'd3;
    localparam logic [3:0] KIND_EQ    = 4'd4;
    localparam logic [3:0] KIND_LP    = 4'd5;
    localparam logic [3:0] KIND_RP    = 4'd6;
    localparam logic [3:0] KIND_COMMA = 4'd7;
    localparam logic [3:0] KIND_END   = 4'd8;

    // characters of interest
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_SEMI    = 8'h3b;
    localparam logic [7:0] CH_EQ      = 8'h3d;
    localparam logic [7:0] CH_LP      = 8'h28;
    localparam logic [7:0] CH_RP      = 8'h29;
    localparam logic [7:0] CH_COMMA   = 8'h2c;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;

    // one result beat
    typedef struct packed {
        logic [3:0]               kind;
        logic                     has_char;
        logic [7:0]               char_value;
        logic                     tok_start;
        logic                     tok_end;
        logic [LINE_OUT_BITS-1:0] line_number;
        logic                     last;
    } piece_t;

endpackage

// ===== rtl/stsc_decode.sv =====
`timescale 1ns / 1ps
// stsc_decode: one scan step, combinational; up to two pieces per text byte
// depends on stsc_pkg

module stsc_decode #(
    parameter int LINE_BITS = stsc_pkg::LINE_BITS_DEFAULT
) (
    input  logic [1:0]           mode,
    input  logic [LINE_BITS-1:0] line_count,
    input  logic [7:0]           text_byte,
    input  logic                 end_of_text,
    output logic [1:0]           mode_next,
    output logic [LINE_BITS-1:0] line_next,
    output logic [1:0]           piece_count,
    output stsc_pkg::piece_t     piece0,
    output stsc_pkg::piece_t     piece1
);

    logic                                is_digit;
    logic                                is_letter;
    logic                                is_blank;
    logic [3:0]                          open_kind;
    logic [stsc_pkg::LINE_OUT_BITS-1:0]  line_out;

    // idle handling of the byte
    logic                                idle_emit;
    logic                                idle_line_inc;
    logic [1:0]                          idle_mode;
    stsc_pkg::piece_t                    idle_piece;
    stsc_pkg::piece_t                    close_piece;
    stsc_pkg::piece_t                    end_piece;
    stsc_pkg::piece_t                    char_piece;

    assign line_out  = stsc_pkg::LINE_OUT_BITS'(line_count);
    assign is_digit  = (text_byte >= 8'h30) && (text_byte <= 8'h39);
    assign is_letter = ((text_byte >= 8'h61) && (text_byte <= 8'h7a)) ||
                       ((text_byte >= 8'h41) && (text_byte <= 8'h5a));
    assign is_blank  = text_byte inside {8'h20, 8'h09, 8'h0b, 8'h0c, 8'h0d};

    always_comb
    begin
        case (mode)
            stsc_pkg::MODE_STR: open_kind = stsc_pkg::KIND_STR;
            stsc_pkg::MODE_INT: open_kind = stsc_pkg::KIND_INT;
            default:            open_kind = stsc_pkg::KIND_ID;
        endcase
    end

    always_comb
    begin
        close_piece             = '0;
        close_piece.kind        = open_kind;
        close_piece.tok_end     = 1'b1;
        close_piece.line_number = line_out;

        end_piece               = '0;
        end_piece.kind          = stsc_pkg::KIND_END;
        end_piece.tok_start     = 1'b1;
        end_piece.tok_end       = 1'b1;
        end_piece.line_number   = line_out;

        char_piece              = '0;
        char_piece.kind         = open_kind;
        char_piece.has_char     = 1'b1;
        char_piece.char_value   = text_byte;
        char_piece.line_number  = line_out;
    end

    always_comb
    begin
        idle_emit              = 1'b1;
        idle_line_inc          = 1'b0;
        idle_mode              = stsc_pkg::MODE_IDLE;
        idle_piece             = '0;
        idle_piece.has_char    = 1'b1;
        idle_piece.char_value  = text_byte;
        idle_piece.tok_start   = 1'b1;
        idle_piece.tok_end     = 1'b1;
        idle_piece.line_number = line_out;
        if (is_blank)
        begin
            idle_emit = 1'b0;
        end
        else if (text_byte == stsc_pkg::CH_QUOTE)
        begin
            idle_mode             = stsc_pkg::MODE_STR;
            idle_piece.kind       = stsc_pkg::KIND_STR;
            idle_piece.has_char   = 1'b0;
            idle_piece.char_value = 8'd0;
            idle_piece.tok_end    = 1'b0;
        end
        else if (is_digit)
        begin
            idle_mode          = stsc_pkg::MODE_INT;
            idle_piece.kind    = stsc_pkg::KIND_INT;
            idle_piece.tok_end = 1'b0;
        end
        else if (is_letter)
        begin
            idle_mode          = stsc_pkg::MODE_ID;
            idle_piece.kind    = stsc_pkg::KIND_ID;
            idle_piece.tok_end = 1'b0;
        end
        else
        begin
            case (text_byte)
                stsc_pkg::CH_SEMI:  idle_piece.kind = stsc_pkg::KIND_SEMI;
                stsc_pkg::CH_EQ:    idle_piece.kind = stsc_pkg::KIND_EQ;
                stsc_pkg::CH_LP:    idle_piece.kind = stsc_pkg::KIND_LP;
                stsc_pkg::CH_RP:    idle_piece.kind = stsc_pkg::KIND_RP;
                stsc_pkg::CH_COMMA: idle_piece.kind = stsc_pkg::KIND_COMMA;
                default:
                begin
                    idle_emit     = 1'b0;
                    idle_line_inc = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        mode_next   = mode;
        line_next   = line_count;
        piece_count = 2'd0;
        piece0      = idle_piece;
        piece1      = idle_piece;
        if (end_of_text)
        begin
            mode_next = stsc_pkg::MODE_IDLE;
            if (mode != stsc_pkg::MODE_IDLE)
            begin
                piece0      = close_piece;
                piece1      = end_piece;
                piece_count = 2'd2;
            end
            else
            begin
                piece0      = end_piece;
                piece_count = 2'd1;
            end
        end
        else if (mode == stsc_pkg::MODE_STR)
        begin
            piece_count = 2'd1;
            if (text_byte == stsc_pkg::CH_QUOTE || text_byte == stsc_pkg::CH_NEWLINE)
            begin
                piece0    = close_piece;
                mode_next = stsc_pkg::MODE_IDLE;
            end
            else
            begin
                piece0 = char_piece;
            end
        end
        else if (mode != stsc_pkg::MODE_IDLE)
        begin
            if (is_digit || (mode == stsc_pkg::MODE_ID && is_letter))
            begin
                piece0      = char_piece;
                piece_count = 2'd1;
            end
            else
            begin
                // close the token, then treat the byte as if idle
                piece0      = close_piece;
                piece1      = idle_piece;
                piece_count = idle_emit ? 2'd2 : 2'd1;
                mode_next   = idle_mode;
                line_next   = line_count + LINE_BITS'(idle_line_inc);
            end
        end
        else
        begin
            piece0      = idle_piece;
            piece_count = idle_emit ? 2'd1 : 2'd0;
            mode_next   = idle_mode;
            line_next   = line_count + LINE_BITS'(idle_line_inc);
        end

        // the final piece of this byte carries the last flag
        piece0.last = (piece_count == 2'd1);
        piece1.last = 1'b1;
    end

endmodule

// ===== rtl/stsc_piece_queue.sv =====
`timescale 1ns / 1ps
// stsc_piece_queue: three-entry result queue, takes up to two pieces a cycle
// depends on stsc_pkg

module stsc_piece_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       push_count,
    input  stsc_pkg::piece_t push0,
    input  stsc_pkg::piece_t push1,
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output stsc_pkg::piece_t out_piece
);

    localparam int DEPTH = 3;

    stsc_pkg::piece_t entry_reg [DEPTH];
    logic [1:0]       head_reg;
    logic [1:0]       head_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic [1:0]       tail;
    logic [1:0]       tail_plus;
    logic             pop;

    function automatic logic [1:0] slot_inc(input logic [1:0] slot);
        return (slot == 2'(DEPTH - 1)) ? 2'd0 : slot + 2'd1;
    endfunction

    function automatic logic [1:0] slot_add(input logic [1:0] slot, input logic [1:0] n);
        logic [2:0] sum;
        sum = {1'b0, slot} + {1'b0, n};
        return (sum >= 3'(DEPTH)) ? 2'(sum - 3'(DEPTH)) : sum[1:0];
    endfunction

    // room for two more pieces, taken from registered state only
    assign room      = (count_reg <= 2'd1);
    assign out_valid = (count_reg != 2'd0);
    assign out_piece = entry_reg[head_reg];
    assign pop       = out_valid && out_ready;
    assign tail      = slot_add(head_reg, count_reg);
    assign tail_plus = slot_inc(tail);
    assign head_next = pop ? slot_inc(head_reg) : head_reg;
    assign count_next = count_reg + push_count - {1'b0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 2'd0;
            count_reg <= 2'd0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            entry_reg[tail] <= push0;
        end
        if (push_count == 2'd2)
        begin
            entry_reg[tail_plus] <= push1;
        end
    end

endmodule

// ===== rtl/script_token_scanner.sv =====
`timescale 1ns / 1ps
// script_token_scanner: top level of the streaming text tokenizer
// depends on stsc_pkg, stsc_decode and stsc_piece_queue
//
// usage
//   input stream: one text byte per beat on s_tdata; a beat with s_tlast high
//   marks end of text (its data byte is ignored), closes any open token and
//   yields an end token
//   output stream: one token piece per beat; m_tuser carries the token kind
//   and whether m_tdata holds a character, m_tlast flags the final piece that
//   one input beat gives (a byte gives zero, one or two pieces)
//   path: an accepted byte waits in the input register, is scanned into the
//   result queue once it has room for two pieces, and its first piece is then
//   shown on the output from the head of that queue
//   throughput: one byte per cycle while each byte gives at most one piece and
//   m_tready is high; a byte that gives two pieces needs a beat for each, so the
//   rate is set by the single output port draining the three-entry result queue
//   stall: with m_tready low the queue fills; s_tready drops once it cannot
//   take two more pieces and the input register is occupied; nothing is lost
//   reset: rst_n clears the scan mode to idle, the line count to one and
//   empties the input register and the result queue

module script_token_scanner #(
    parameter int LINE_BITS = stsc_pkg::LINE_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // end_of_text
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] char_value, [8] token_start,
                                   // [9] token_end, [25:10] line_number, [31:26] zero
    output logic [4:0]  m_tuser,   // [3:0] token_kind, [4] has_char
    output logic        m_tlast    // last piece of this input beat
);

    // scanner state
    logic [1:0]           mode_reg;
    logic [1:0]           mode_next;
    logic [LINE_BITS-1:0] line_reg;
    logic [LINE_BITS-1:0] line_next;

    // input register
    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [7:0]           in_byte_reg;
    logic                 in_eot_reg;
    logic                 in_take;

    // decode to queue
    logic [1:0]           piece_count;
    logic [1:0]           push_count;
    stsc_pkg::piece_t     piece0;
    stsc_pkg::piece_t     piece1;
    stsc_pkg::piece_t     out_piece;
    logic                 room;
    logic                 fire;

    // a held byte is scanned once the queue can take both of its pieces
    assign fire       = in_valid_reg && room;
    assign s_tready   = !in_valid_reg || fire;
    assign in_take    = s_tvalid && s_tready;
    assign push_count = fire ? piece_count : 2'd0;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            mode_reg     <= stsc_pkg::MODE_IDLE;
            line_reg     <= LINE_BITS'(1);
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (fire)
            begin
                mode_reg <= mode_next;
                line_reg <= line_next;
            end
        end
    end

    // payload of the input register, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= s_tdata;
            in_eot_reg  <= s_tlast;
        end
    end

    stsc_decode #(
        .LINE_BITS (LINE_BITS)
    ) u_decode (
        .mode        (mode_reg),
        .line_count  (line_reg),
        .text_byte   (in_byte_reg),
        .end_of_text (in_eot_reg),
        .mode_next   (mode_next),
        .line_next   (line_next),
        .piece_count (piece_count),
        .piece0      (piece0),
        .piece1      (piece1)
    );

    stsc_piece_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push0      (piece0),
        .push1      (piece1),
        .room       (room),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_piece  (out_piece)
    );

    // pack the piece onto the output beat
    assign m_tdata = {6'd0, out_piece.line_number, out_piece.tok_end,
                      out_piece.tok_start, out_piece.char_value};
    assign m_tuser = {out_piece.has_char, out_piece.kind};
    assign m_tlast = out_piece.last;

endmodule
